/* sv/rtmp_message_chunker_defines.svh */
// ----------------------------------------------------------------------------
// rtmp message chunker assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef RTMP_MESSAGE_CHUNKER_DEFINES_SVH
`define RTMP_MESSAGE_CHUNKER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define RMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/rmc_pkg.sv */
// ----------------------------------------------------------------------------
// rmc_pkg
// shared types and constants of the message chunker
// ----------------------------------------------------------------------------
`default_nettype none

package rmc_pkg;

  localparam int unsigned QUEUE_DEPTH      = 4;
  localparam logic [23:0] CHUNK_LEN_RESET  = 24'd128;
  localparam logic [1:0]  TYPE3_FMT        = 2'b11;
  localparam logic [3:0]  HDR_LAST_IDX     = 4'd11;
  localparam int unsigned HDR_BITS         = 96;

  typedef enum logic {
    ACT_START   = 1'b0,
    ACT_PAYLOAD = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    CMD_HDR  = 2'd0,
    CMD_DATA = 2'd1,
    CMD_ERR  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        cont;
    logic        eom;
    logic [5:0]  channel;
    logic [7:0]  msg_type;
    logic [23:0] msg_length;
    logic [31:0] msg_stream;
    logic [23:0] time_stamp;
    logic [7:0]  data;
  } cmd_t;

endpackage

`default_nettype wire

/* sv/rtmp_message_chunker.sv */
// a taken item goes to the queue; its first byte then goes to the output byte register
// throughput: one byte per cycle when not stalled, set by the single output byte register
// a start item gives 12 bytes, a payload item 1, or 2 when a continuation header goes first
// the queue between front and back keeps taking items while output bytes wait, until full
// reset: synchronous, active low; clears message state and queue, chunk size to 128
// ----------------------------------------------------------------------------
// rtmp_message_chunker
// top level: splits messages into type-0 and type-3 chunks
// ----------------------------------------------------------------------------
`default_nettype none

module rtmp_message_chunker
  import rmc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [23:0] cfg_chunk_len,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_action,
  input  wire  [7:0]  in_msg_type,
  input  wire  [23:0] in_msg_length,
  input  wire  [5:0]  in_channel_id,
  input  wire  [31:0] in_msg_stream,
  input  wire  [23:0] in_time_stamp,
  input  wire  [7:0]  in_payload_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run,
  output logic        out_end_of_message,
  output logic        out_error
);

  cmd_t wr_cmd, rd_cmd;
  logic q_push, q_pop, q_full, q_empty;

  rmc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_chunk_len   (cfg_chunk_len),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_msg_type     (in_msg_type),
    .in_msg_length   (in_msg_length),
    .in_channel_id   (in_channel_id),
    .in_msg_stream   (in_msg_stream),
    .in_time_stamp   (in_time_stamp),
    .in_payload_byte (in_payload_byte),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (wr_cmd)
  );

  rmc_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_cmd (wr_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_cmd (rd_cmd)
  );

  rmc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_cmd              (rd_cmd),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_last_of_run    (out_last_of_run),
    .out_end_of_message (out_end_of_message),
    .out_error          (out_error)
  );

endmodule

`default_nettype wire

/* sv/rmc_queue.sv */
// ----------------------------------------------------------------------------
// rmc_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module rmc_queue
  import rmc_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  push,
  input  cmd_t wr_cmd,
  output logic full,
  input  wire  pop,
  output logic empty,
  output cmd_t rd_cmd
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);
  assign rd_cmd = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

/* sv/rmc_front.sv */
// ----------------------------------------------------------------------------
// rmc_front
// accepts items, tracks message state and chunk fill, issues commands
// ----------------------------------------------------------------------------
`default_nettype none

module rmc_front
  import rmc_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [23:0] cfg_chunk_len,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_action,
  input  wire  [7:0]  in_msg_type,
  input  wire  [23:0] in_msg_length,
  input  wire  [5:0]  in_channel_id,
  input  wire  [31:0] in_msg_stream,
  input  wire  [23:0] in_time_stamp,
  input  wire  [7:0]  in_payload_byte,
  input  wire         q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic [23:0] chunk_len_r;
  logic [23:0] remaining_r, remaining_nxt;
  logic [23:0] fill_r, fill_nxt;
  logic [5:0]  channel_r, channel_nxt;
  logic [23:0] limit;
  logic        need_cont;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;
  assign limit     = (chunk_len_r == '0) ? 24'd1 : chunk_len_r;
  assign need_cont = (fill_r >= limit);

  always_comb begin
    remaining_nxt    = remaining_r;
    fill_nxt         = fill_r;
    channel_nxt      = channel_r;
    q_cmd            = '0;
    q_cmd.msg_type   = in_msg_type;
    q_cmd.msg_length = in_msg_length;
    q_cmd.msg_stream = in_msg_stream;
    q_cmd.time_stamp = in_time_stamp;
    q_cmd.data       = in_payload_byte;
    q_cmd.channel    = channel_r;
    if (action_t'(in_action) == ACT_START) begin
      q_cmd.kind    = CMD_HDR;
      q_cmd.channel = in_channel_id;
      q_cmd.eom     = (in_msg_length == '0);
      remaining_nxt = in_msg_length;
      fill_nxt      = '0;
      channel_nxt   = in_channel_id;
    end else if (remaining_r == '0) begin
      q_cmd.kind = CMD_ERR;
    end else begin
      q_cmd.kind    = CMD_DATA;
      q_cmd.cont    = need_cont;
      q_cmd.eom     = (remaining_r == 24'd1);
      remaining_nxt = remaining_r - 1'b1;
      fill_nxt      = (need_cont ? 24'd0 : fill_r) + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_len_r <= CHUNK_LEN_RESET;
      remaining_r <= '0;
      fill_r      <= '0;
      channel_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        chunk_len_r <= cfg_chunk_len;
      end
      if (q_push) begin
        remaining_r <= remaining_nxt;
        fill_r      <= fill_nxt;
        channel_r   <= channel_nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/rmc_back.sv */
// ----------------------------------------------------------------------------
// rmc_back
// serialises queued commands into output bytes, one byte per cycle unless the output stalls
// ----------------------------------------------------------------------------
`default_nettype none

module rmc_back
  import rmc_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        q_empty,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic       out_end_of_message,
  output logic       out_error
);

  logic [3:0]          idx_r, idx_nxt;
  logic                out_valid_r;
  logic [7:0]          byte_r;
  logic                last_r, eom_r, err_r;
  logic [HDR_BITS-1:0] hdr_w, hdr_sh;
  logic                load, adv;
  logic [7:0]          sel_byte;
  logic                sel_last, sel_eom, sel_err;

  assign hdr_w = {2'b00, q_cmd.channel, q_cmd.time_stamp, q_cmd.msg_length, q_cmd.msg_type,
                  q_cmd.msg_stream[7:0], q_cmd.msg_stream[15:8], q_cmd.msg_stream[23:16],
                  q_cmd.msg_stream[31:24]};
  assign hdr_sh = hdr_w << {idx_r, 3'b000};

  assign load  = !out_valid_r || !out_stall;
  assign adv   = !q_empty && load;
  assign q_pop = adv && sel_last;

  always_comb begin
    sel_byte = '0;
    sel_last = 1'b1;
    sel_eom  = 1'b0;
    sel_err  = 1'b0;
    unique case (q_cmd.kind)
      CMD_HDR: begin
        sel_byte = hdr_sh[HDR_BITS-1 -: 8];
        sel_last = (idx_r == HDR_LAST_IDX);
        sel_eom  = sel_last && q_cmd.eom;
      end
      CMD_DATA: begin
        if (q_cmd.cont && (idx_r == '0)) begin
          sel_byte = {TYPE3_FMT, q_cmd.channel};
          sel_last = 1'b0;
        end else begin
          sel_byte = q_cmd.data;
          sel_eom  = q_cmd.eom;
        end
      end
      CMD_ERR: begin
        sel_err = 1'b1;
      end
      default: begin
        sel_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (adv) begin
      idx_nxt = sel_last ? 4'd0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        out_valid_r <= !q_empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      byte_r <= sel_byte;
      last_r <= sel_last;
      eom_r  <= sel_eom;
      err_r  <= sel_err;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = byte_r;
  assign out_last_of_run    = last_r;
  assign out_end_of_message = eom_r;
  assign out_error          = err_r;

endmodule

`default_nettype wire

/* sv/rmc_checker.sv */
// ----------------------------------------------------------------------------
// rmc_checker
// port-level checks on the chunked output stream
// ----------------------------------------------------------------------------
`default_nettype none

`include "rtmp_message_chunker_defines.svh"

module rmc_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_stall,
  input wire [7:0] out_byte,
  input wire       out_last_of_run,
  input wire       out_end_of_message,
  input wire       out_error
);

  `RMC_ASSERT_NOW(a_err_form, out_valid && out_error, out_last_of_run && !out_end_of_message && (out_byte == 8'd0), "dropped item result malformed")
  `RMC_ASSERT_NOW(a_eom_last, out_valid && out_end_of_message, out_last_of_run, "end of message not on last byte of item")
  `RMC_ASSERT_NOW(a_mid_clean, out_valid && !out_last_of_run, !out_error && !out_end_of_message, "flags set inside a run")
  `RMC_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_last_of_run), "stalled item changed")

endmodule

bind rtmp_message_chunker rmc_checker u_rmc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_byte           (out_byte),
  .out_last_of_run    (out_last_of_run),
  .out_end_of_message (out_end_of_message),
  .out_error          (out_error)
);

`default_nettype wire
